// ===== sv/key_debounce_press_classifier_core_assert.svh =====
// Assertion helpers for the key debounce block. Both expect clk and rst_n in scope.
`ifndef KEY_DEBOUNCE_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`define KEY_DEBOUNCE_PRESS_CLASSIFIER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define KDPC_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KDPC_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

// ===== sv/kdpc_pkg.sv =====
package kdpc_pkg;

  localparam int PINS = 8;

  localparam int LEVEL_W     = 8;
  localparam int KEY_W       = 3;
  localparam int KIND_W      = 3;
  localparam int SEQ_W       = 32;
  localparam int LIMIT_W     = 8;
  localparam int PERIOD_W    = 16;
  localparam int COUNT_W     = 8;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int PRESS_CNT_W = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERT = 2'd3;

  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 8'd4;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd40;
  localparam logic [COUNT_W-1:0]  LONG_RST   = 8'd5;
  localparam logic [LEVEL_W-1:0]  INVERT_RST = 8'd0;

  typedef enum logic [KIND_W-1:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_SHORT   = 3'd2,
    EV_LONG    = 3'd3,
    EV_REPEAT  = 3'd4
  } ev_kind_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  limit;
    logic [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]  long_cnt;
  } lane_cfg_t;

  // Events one lane found on a tick: an optional first event and an optional Release.
  typedef struct packed {
    logic             pend0;
    ev_kind_t         kind0;
    logic             pend1;
    logic [SEQ_W-1:0] seq;
  } lane_ev_t;

endpackage

// ===== sv/kdpc_lane.sv =====
module kdpc_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        level,
  input  kdpc_pkg::lane_cfg_t         cfg,
  input  logic [kdpc_pkg::SEQ_W-1:0]  seq_in,
  output logic                        press,
  output kdpc_pkg::lane_ev_t          ev
);

  logic [kdpc_pkg::LIMIT_W-1:0]  integ_r, integ_nxt;
  logic                          stable_r, stable_nxt;
  logic [kdpc_pkg::PERIOD_W-1:0] ticks_r, ticks_nxt;
  logic                          running_r, running_nxt;
  logic [kdpc_pkg::COUNT_W-1:0]  fc_r, fc_nxt;
  logic [kdpc_pkg::SEQ_W-1:0]    kseq_r, kseq_nxt;

  logic                          at_end;
  logic                          change;
  logic [kdpc_pkg::PERIOD_W:0]   tick_inc;
  logic                          fires;
  logic [kdpc_pkg::COUNT_W-1:0]  fc_inc;

  // The press flag feeds the sequence numbering, so it depends on the pin and lane state, not on seq_in.
  always_comb begin
    integ_nxt = integ_r;
    if (level) begin
      if (integ_r < cfg.limit) integ_nxt = integ_r + 8'd1;
    end else if (integ_r != '0) begin
      integ_nxt = integ_r - 8'd1;
    end

    at_end = !((integ_nxt != '0) && (integ_nxt < cfg.limit));
    change = at_end && (stable_r != level);
    press  = change && level;
  end

  always_comb begin
    tick_inc = {1'b0, ticks_r} + 17'd1;
    // A period of zero compares like a period of one: every tick fires.
    fires    = tick_inc >= {1'b0, cfg.period};
    fc_inc   = fc_r + 8'd1;

    stable_nxt  = stable_r;
    ticks_nxt   = ticks_r;
    running_nxt = running_r;
    fc_nxt      = fc_r;
    kseq_nxt    = kseq_r;
    ev.pend0    = 1'b0;
    ev.kind0    = kdpc_pkg::EV_PRESS;
    ev.pend1    = 1'b0;

    if (change) begin
      stable_nxt = level;
      ticks_nxt  = '0;
      if (level) begin
        kseq_nxt    = seq_in;
        running_nxt = 1'b1;
        ev.pend0    = 1'b1;
        ev.kind0    = kdpc_pkg::EV_PRESS;
      end else begin
        running_nxt = 1'b0;
        fc_nxt      = '0;
        ev.pend0    = fc_r < cfg.long_cnt;
        ev.kind0    = kdpc_pkg::EV_SHORT;
        ev.pend1    = 1'b1;
      end
    end else if (running_r) begin
      if (fires) begin
        ticks_nxt = '0;
        if (fc_r < cfg.long_cnt) begin
          fc_nxt   = fc_inc;
          ev.pend0 = fc_inc == cfg.long_cnt;
          ev.kind0 = kdpc_pkg::EV_LONG;
        end else begin
          ev.pend0 = 1'b1;
          ev.kind0 = kdpc_pkg::EV_REPEAT;
        end
      end else begin
        ticks_nxt = tick_inc[kdpc_pkg::PERIOD_W-1:0];
      end
    end
    ev.seq = kseq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r   <= '0;
      stable_r  <= 1'b0;
      ticks_r   <= '0;
      running_r <= 1'b0;
      fc_r      <= '0;
      kseq_r    <= '0;
    end else if (en) begin
      integ_r   <= integ_nxt;
      stable_r  <= stable_nxt;
      ticks_r   <= ticks_nxt;
      running_r <= running_nxt;
      fc_r      <= fc_nxt;
      kseq_r    <= kseq_nxt;
    end
  end

endmodule

// ===== sv/kdpc_merge.sv =====
module kdpc_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  kdpc_pkg::lane_ev_t                lane_ev [kdpc_pkg::PINS],
  output logic                              busy,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kdpc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);

  logic [kdpc_pkg::PINS-1:0]  pend0_r, pend0_nxt, pend0_clr;
  logic [kdpc_pkg::PINS-1:0]  pend1_r, pend1_nxt, pend1_clr;
  kdpc_pkg::ev_kind_t         kind0_r [kdpc_pkg::PINS];
  logic [kdpc_pkg::SEQ_W-1:0] seq_r   [kdpc_pkg::PINS];

  logic                              found;
  logic                              take;
  logic [kdpc_pkg::KEY_W-1:0]        idx_sel;
  kdpc_pkg::ev_kind_t                kind_sel;
  logic [kdpc_pkg::SEQ_W-1:0]        seq_sel;
  logic                              last_sel;
  logic                              ovalid_r, ovalid_nxt;
  logic [kdpc_pkg::OUT_TDATA_W-1:0]  odata_r;
  logic                              olast_r;

  // Lowest pin first; within a pin the first event goes before its Release.
  always_comb begin
    found     = 1'b0;
    idx_sel   = '0;
    kind_sel  = kdpc_pkg::EV_RELEASE;
    seq_sel   = '0;
    pend0_clr = pend0_r;
    pend1_clr = pend1_r;
    for (int i = 0; i < kdpc_pkg::PINS; i++) begin
      if (!found && (pend0_r[i] || pend1_r[i])) begin
        found   = 1'b1;
        idx_sel = 3'(i);
        seq_sel = seq_r[i];
        if (pend0_r[i]) begin
          kind_sel     = kind0_r[i];
          pend0_clr[i] = 1'b0;
        end else begin
          kind_sel     = kdpc_pkg::EV_RELEASE;
          pend1_clr[i] = 1'b0;
        end
      end
    end
    last_sel = (pend0_clr == '0) && (pend1_clr == '0);
    take     = found && (!ovalid_r || out_tready);

    pend0_nxt = take ? pend0_clr : pend0_r;
    pend1_nxt = take ? pend1_clr : pend1_r;
    if (load) begin
      for (int i = 0; i < kdpc_pkg::PINS; i++) begin
        pend0_nxt[i] = lane_ev[i].pend0;
        pend1_nxt[i] = lane_ev[i].pend1;
      end
    end

    if (take) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  assign busy = found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend0_r  <= '0;
      pend1_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      pend0_r  <= pend0_nxt;
      pend1_r  <= pend1_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < kdpc_pkg::PINS; i++) begin
        kind0_r[i] <= lane_ev[i].kind0;
        seq_r[i]   <= lane_ev[i].seq;
      end
    end
    if (take) begin
      odata_r <= {2'b00, seq_sel, kind_sel, idx_sel};
      olast_r <= last_sel;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule

// ===== sv/key_debounce_press_classifier_core.sv =====
// Key debounce and press classifier.
// Input stream: one transfer per tick; in_tdata bit i is the raw level of key pin i.
// Output stream: one transfer per key event (press, release, short, long, repeat);
// out_tlast marks the final event caused by a tick.
// Configuration: cfg_wr_en with cfg_addr 0 debounce limit, 1 press period,
// 2 long press count, 3 invert mask; write only while the block is idle.
// Each pin has its own lane with integrator, press timer and firing count, all
// updated in the cycle a tick is accepted. The lanes' events sit in a pending
// buffer that a merge stage drains in pin order, one event per cycle while the
// output accepts, into an output register.
// The first event of a tick passes the pending buffer and then the output register.
// A tick with events holds the pending buffer until its last event is drained, and no
// new tick is taken meanwhile (a tick has up to sixteen events); ticks
// without events are taken every cycle. The output register holds the last event
// of a tick while the next tick is already taken.
// A stalled receiver holds the output register and, once the buffer still holds
// events, in_tready stays low. Reset restores the default configuration, marks
// every key released with its integrator and timer cleared, and empties the output.
module key_debounce_press_classifier_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kdpc_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] pin_levels
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [kdpc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [2:0] key_index, [5:3] event_kind,
                                                         // [37:6] sequence_res, [39:38] zero
  output logic                               out_tlast,  // last_of_tick
  input  logic                               cfg_wr_en,
  input  logic [kdpc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [kdpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [kdpc_pkg::LIMIT_W-1:0]  limit_r;
  logic [kdpc_pkg::PERIOD_W-1:0] period_r;
  logic [kdpc_pkg::COUNT_W-1:0]  long_r;
  logic [kdpc_pkg::LEVEL_W-1:0]  invert_r;
  logic [kdpc_pkg::SEQ_W-1:0]    gseq_r, gseq_nxt;

  kdpc_pkg::lane_cfg_t           lane_cfg;
  logic [kdpc_pkg::LEVEL_W-1:0]  levels;
  logic                          in_fire;
  logic                          busy;
  logic [kdpc_pkg::PINS-1:0]     press;
  logic [kdpc_pkg::SEQ_W-1:0]    lane_seq [kdpc_pkg::PINS];
  kdpc_pkg::lane_ev_t            lane_ev  [kdpc_pkg::PINS];
  logic [kdpc_pkg::PRESS_CNT_W-1:0] press_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= kdpc_pkg::LIMIT_RST;
      period_r <= kdpc_pkg::PERIOD_RST;
      long_r   <= kdpc_pkg::LONG_RST;
      invert_r <= kdpc_pkg::INVERT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        kdpc_pkg::CFG_LIMIT:  limit_r  <= cfg_wdata[kdpc_pkg::LIMIT_W-1:0];
        kdpc_pkg::CFG_PERIOD: period_r <= cfg_wdata[kdpc_pkg::PERIOD_W-1:0];
        kdpc_pkg::CFG_LONG:   long_r   <= cfg_wdata[kdpc_pkg::COUNT_W-1:0];
        kdpc_pkg::CFG_INVERT: invert_r <= cfg_wdata[kdpc_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign lane_cfg.limit    = limit_r;
  assign lane_cfg.period   = period_r;
  assign lane_cfg.long_cnt = long_r;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign levels    = in_tdata ^ invert_r;

  // Presses in lower pins of the same tick take the earlier sequence numbers.
  always_comb begin
    press_cnt = '0;
    for (int i = 0; i < kdpc_pkg::PINS; i++) begin
      lane_seq[i] = gseq_r + 32'(press_cnt) + 32'd1;
      if (press[i]) press_cnt = press_cnt + 4'd1;
    end
    gseq_nxt = gseq_r + 32'(press_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gseq_r <= '0;
    end else if (in_fire) begin
      gseq_r <= gseq_nxt;
    end
  end

  for (genvar g = 0; g < kdpc_pkg::PINS; g++) begin : g_lane
    kdpc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (in_fire),
      .level  (levels[g]),
      .cfg    (lane_cfg),
      .seq_in (lane_seq[g]),
      .press  (press[g]),
      .ev     (lane_ev[g])
    );
  end

  kdpc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .lane_ev    (lane_ev),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sv/kdpc_checker.sv =====
`include "key_debounce_press_classifier_core_assert.svh"

module kdpc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [kdpc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                               out_tlast
);

  // A stalled event keeps its contents.
  `KDPC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled event changed")

  // The output is empty right after reset.
  `KDPC_ASSERT_NOW(a_out_reset, $past(!rst_n), !out_tvalid, "event valid after reset")

  // While a tick still has events behind the one shown, no new tick is taken.
  `KDPC_ASSERT_NOW(a_no_overlap, out_tvalid && !out_tlast, !in_tready,
    "tick accepted while events of the previous tick are pending")

  // Short is always followed by Release of the same key in the same tick.
  `KDPC_ASSERT_NOW(a_short_not_last,
    out_tvalid && (out_tdata[5:3] == kdpc_pkg::EV_SHORT), !out_tlast,
    "short event closed a tick")

endmodule

bind key_debounce_press_classifier_core kdpc_checker u_kdpc_checker (.*);
